>>> hw/rtl/rd_pkg.sv
// Shared types and constants for the reversible deque.
// Used by rd_cell, rd_chain and reversible_deque; depends on nothing.
package rd_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int DATA_W    = 32;
    localparam int MODE_W    = 3;
    localparam int KIND_W    = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD         = 3'd0,
        MODE_VIP         = 3'd1,
        MODE_SERVE_FRONT = 3'd2,
        MODE_SERVE_BACK  = 3'd3,
        MODE_REVERSE     = 3'd4,
        MODE_PRINT       = 3'd5
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ELEM  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_FULL  = 2'd2
    } kind_t;

    // Per-cycle operation applied by every cell of the chain.
    typedef enum logic [2:0] {
        OP_HOLD      = 3'd0,
        OP_INS_HEAD  = 3'd1,
        OP_INS_TAIL  = 3'd2,
        OP_DEL_HEAD  = 3'd3,
        OP_DEL_TAIL  = 3'd4,
        OP_ROT_LEFT  = 3'd5,
        OP_ROT_RIGHT = 3'd6
    } chain_op_t;

    typedef struct packed {
        chain_op_t         op;
        logic [DATA_W-1:0] push_value;
    } chain_ctrl_t;

endpackage

>>> hw/rtl/reversible_deque.sv
// Reversible deque of signed 32-bit values kept in a shifting chain of cells.
//
// Channels: cmd (mode, value) in, rsp (kind, element, last) out; each moves one
// beat when valid is high and stall is low. Commands: add to the logical back,
// vip to the logical front, serve front, serve back, reverse, print.
// Add, vip and serve, unless refused as full or empty, shift the whole chain or
// write or clear the tail cell as taken; these and reverse need no busy state,
// so a new command can follow unless rsp holds a stalled beat. A serve beat or
// a full/empty status beat appears on rsp the cycle after the command is taken.
// Print rotates the chain one cell per cycle while rsp is not stalled and emits
// one beat per stored element from the print state through the output register,
// with last set on the final beat; cmd is stalled while the walk runs.
// Reverse only flips a flag that selects which physical end is the front.
// One output register holds a waiting beat; while rsp is stalled with a beat
// held, cmd is stalled and a running print freezes in place.
// Reset empties the deque and clears the reverse flag at once; stored words
// are not cleared, only the valid bits of the cells.
module reversible_deque #(
    parameter int DEPTH = rd_pkg::DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  logic [rd_pkg::MODE_W-1:0]           mode,
    input  logic signed [rd_pkg::DATA_W-1:0]    value,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [rd_pkg::KIND_W-1:0]           kind,
    output logic signed [rd_pkg::DATA_W-1:0]    element,
    output logic                                last
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_PRINT = 2'b10
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic                      rev_reg;
    logic                      rev_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [CNT_W-1:0]          walk_reg;
    logic [CNT_W-1:0]          walk_next;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    rd_pkg::kind_t             kind_reg;
    rd_pkg::kind_t             kind_next;
    logic [rd_pkg::DATA_W-1:0] elem_reg;
    logic [rd_pkg::DATA_W-1:0] elem_next;
    logic                      last_reg;
    logic                      last_next;

    rd_pkg::chain_ctrl_t       ctrl;
    rd_pkg::mode_t             mode_code;
    logic [rd_pkg::DATA_W-1:0] head_data;
    logic [rd_pkg::DATA_W-1:0] tail_data;
    logic                      empty;
    logic                      full;
    logic                      out_free;
    logic                      cmd_fire;
    logic                      walk_done;

    rd_chain #(
        .DEPTH (DEPTH)
    ) u_chain
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .head_data (head_data),
        .tail_data (tail_data),
        .empty     (empty),
        .full      (full)
    );

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign cmd_stall = (state_reg != ST_IDLE) || !out_free;
    assign cmd_fire  = cmd_valid && !cmd_stall;
    assign mode_code = rd_pkg::mode_t'(mode);
    assign walk_done = (walk_reg + CNT_W'(1)) == count_reg;

    always_comb
    begin
        state_next      = state_reg;
        rev_next        = rev_reg;
        count_next      = count_reg;
        walk_next       = walk_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        kind_next       = kind_reg;
        elem_next       = elem_reg;
        last_next       = last_reg;
        ctrl.op         = rd_pkg::OP_HOLD;
        ctrl.push_value = value;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    unique case (mode_code) inside
                        rd_pkg::MODE_ADD, rd_pkg::MODE_VIP:
                        begin
                            if (full)
                            begin
                                out_valid_next = 1'b1;
                                kind_next      = rd_pkg::KIND_FULL;
                                elem_next      = '0;
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                ctrl.op = ((mode_code == rd_pkg::MODE_ADD) != rev_reg)
                                          ? rd_pkg::OP_INS_TAIL : rd_pkg::OP_INS_HEAD;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        rd_pkg::MODE_SERVE_FRONT, rd_pkg::MODE_SERVE_BACK:
                        begin
                            out_valid_next = 1'b1;
                            last_next      = 1'b1;
                            if (empty)
                            begin
                                kind_next = rd_pkg::KIND_EMPTY;
                                elem_next = '0;
                            end
                            else if ((mode_code == rd_pkg::MODE_SERVE_FRONT) != rev_reg)
                            begin
                                kind_next  = rd_pkg::KIND_ELEM;
                                elem_next  = head_data;
                                ctrl.op    = rd_pkg::OP_DEL_HEAD;
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                kind_next  = rd_pkg::KIND_ELEM;
                                elem_next  = tail_data;
                                ctrl.op    = rd_pkg::OP_DEL_TAIL;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        rd_pkg::MODE_REVERSE:
                        begin
                            rev_next = !rev_reg;
                        end
                        rd_pkg::MODE_PRINT:
                        begin
                            if (empty)
                            begin
                                out_valid_next = 1'b1;
                                kind_next      = rd_pkg::KIND_EMPTY;
                                elem_next      = '0;
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_PRINT;
                                walk_next  = '0;
                            end
                        end
                        default:
                        begin
                            // unused codes: drop the beat
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PRINT:
            begin
                // emit the logical front, then rotate so the next one comes up
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = rd_pkg::KIND_ELEM;
                    elem_next      = rev_reg ? tail_data : head_data;
                    last_next      = walk_done;
                    ctrl.op        = rev_reg ? rd_pkg::OP_ROT_RIGHT : rd_pkg::OP_ROT_LEFT;
                    walk_next      = walk_reg + CNT_W'(1);
                    if (walk_done)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rev_reg       <= 1'b0;
            count_reg     <= '0;
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rev_reg       <= rev_next;
            count_reg     <= count_next;
            walk_reg      <= walk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        elem_reg <= elem_next;
        last_reg <= last_next;
    end

    assign rsp_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign element   = elem_reg;
    assign last      = last_reg;

    // chain flags agree with the element count
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        full == (count_reg == CNT_W'(DEPTH)))
        else $error("full flag and element count disagree");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        empty == (count_reg == '0))
        else $error("empty flag and element count disagree");

    a_print_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PRINT) |-> cmd_stall)
        else $error("command taken during print walk");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PRINT) |-> (walk_reg < count_reg))
        else $error("print walk ran past the element count");

    a_reverse: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && mode_code == rd_pkg::MODE_REVERSE) |=> (rev_reg != $past(rev_reg)))
        else $error("reverse command did not flip the direction");

endmodule

>>> hw/rtl/rd_cell.sv
// One storage cell of the deque chain: a data word and a valid bit.
// Takes from its left or right neighbor as the chain operation says; uses rd_pkg.
module rd_cell
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  rd_pkg::chain_ctrl_t          ctrl,
    input  logic [rd_pkg::DATA_W-1:0]    left_data,
    input  logic                         left_valid,
    input  logic [rd_pkg::DATA_W-1:0]    right_data,
    input  logic                         right_valid,
    input  logic [rd_pkg::DATA_W-1:0]    head_data,
    output logic [rd_pkg::DATA_W-1:0]    data,
    output logic                         valid
);

    logic [rd_pkg::DATA_W-1:0] data_reg;
    logic [rd_pkg::DATA_W-1:0] data_next;
    logic                      valid_reg;
    logic                      valid_next;
    logic                      is_last;
    logic                      first_empty;

    assign is_last     = valid_reg && !right_valid;
    assign first_empty = !valid_reg && left_valid;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        case (ctrl.op)
            rd_pkg::OP_INS_HEAD:
            begin
                data_next  = left_data;
                valid_next = left_valid;
            end
            rd_pkg::OP_INS_TAIL:
            begin
                if (first_empty)
                begin
                    data_next  = ctrl.push_value;
                    valid_next = 1'b1;
                end
            end
            rd_pkg::OP_DEL_HEAD:
            begin
                data_next  = right_data;
                valid_next = right_valid;
            end
            rd_pkg::OP_DEL_TAIL:
            begin
                if (is_last)
                    valid_next = 1'b0;
            end
            rd_pkg::OP_ROT_LEFT:
            begin
                // the tail cell wraps around to the head word
                if (valid_reg)
                    data_next = is_last ? head_data : right_data;
            end
            rd_pkg::OP_ROT_RIGHT:
            begin
                if (valid_reg)
                    data_next = left_data;
            end
            default:
            begin
                data_next  = data_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

>>> hw/rtl/rd_chain.sv
// Row of rd_cell instances holding the deque in physical order, cell 0 at the front.
// Provides head and tail words and the empty and full flags; uses rd_pkg and rd_cell.
module rd_chain #(
    parameter int DEPTH = rd_pkg::DEPTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  rd_pkg::chain_ctrl_t          ctrl,
    output logic [rd_pkg::DATA_W-1:0]    head_data,
    output logic [rd_pkg::DATA_W-1:0]    tail_data,
    output logic                         empty,
    output logic                         full
);

    logic [rd_pkg::DATA_W-1:0] cell_data [DEPTH];
    logic                      cell_valid [DEPTH];
    logic [DEPTH-1:0]          cell_last;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [rd_pkg::DATA_W-1:0] l_data;
            logic                      l_valid;
            logic [rd_pkg::DATA_W-1:0] r_data;
            logic                      r_valid;

            if (i == 0)
            begin : g_head
                // the head cell takes the new word on a front push, the tail word on a right rotate
                assign l_data  = (ctrl.op == rd_pkg::OP_ROT_RIGHT) ? tail_data : ctrl.push_value;
                assign l_valid = 1'b1;
            end
            else
            begin : g_inner_l
                assign l_data  = cell_data[i-1];
                assign l_valid = cell_valid[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_end
                assign r_data  = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_inner_r
                assign r_data  = cell_data[i+1];
                assign r_valid = cell_valid[i+1];
            end

            assign cell_last[i] = cell_valid[i] && !r_valid;

            rd_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .left_data   (l_data),
                .left_valid  (l_valid),
                .right_data  (r_data),
                .right_valid (r_valid),
                .head_data   (head_data),
                .data        (cell_data[i]),
                .valid       (cell_valid[i])
            );
        end
    endgenerate

    // at most one cell is the tail, so an OR picks its word
    always_comb
    begin
        tail_data = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            if (cell_last[k])
                tail_data = tail_data | cell_data[k];
        end
    end

    assign head_data = cell_data[0];
    assign empty     = !cell_valid[0];
    assign full      = cell_valid[DEPTH-1];

endmodule
